[hdl/dmac_pkg.sv]
// Shared types, codes and sizing constants for the DMA burst copy controller.
// No dependencies; every other source file in the project imports this package.
package dmac_pkg;

    // Burst geometry: bursts are a power of two bytes and never cross a burst boundary.
    localparam int BURST_LOG2  = 6;
    localparam int BURST_BYTES = 1 << BURST_LOG2;
    localparam int LEN_W       = BURST_LOG2 + 1;
    localparam int ADDR_W      = 32;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Input word kinds.
    localparam logic [2:0] KIND_REG_WR  = 3'd0;
    localparam logic [2:0] KIND_REG_RD  = 3'd1;
    localparam logic [2:0] KIND_RD_DONE = 3'd2;
    localparam logic [2:0] KIND_WR_DONE = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    // Register indexes.
    localparam logic [2:0] REG_SRC   = 3'd0;
    localparam logic [2:0] REG_DST   = 3'd1;
    localparam logic [2:0] REG_LEN   = 3'd2;
    localparam logic [2:0] REG_ABORT = 3'd3;
    localparam logic [2:0] REG_IRQ   = 3'd4;

    // Input word as it arrives on the bus side.
    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        reg_index;
        logic [ADDR_W-1:0] wdata;
        logic              failed;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic [ADDR_W-1:0]     rdata;
        logic                  access_ok;
        logic                  req_valid;
        logic                  req_write;
        logic [ADDR_W-1:0]     req_addr;
        logic [LEN_W-1:0]      req_len;
        logic [BURST_LOG2-1:0] req_buf_offset;
        logic                  busy_res;
        logic                  irq;
    } t_out_item;

    // Operation after classification by the front part.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_SRC,
        OP_WR_DST,
        OP_WR_LEN,
        OP_WR_ABORT,
        OP_WR_IRQ,
        OP_RD_SRC,
        OP_RD_DST,
        OP_RD_LEN,
        OP_REG_BAD,
        OP_RD_DONE,
        OP_WR_DONE,
        OP_TICK
    } t_op;

    // Classified command held in the queue.
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] wdata;
        logic              failed;
    } t_cmd;

endpackage

[hdl/dmac_front.sv]
// Front part: accepts input words and classifies them into queue commands.
// Depends on dmac_pkg.
module dmac_front
    import dmac_pkg::*;
(
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_not_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    // A word is taken whenever the queue has room and the block is out of reset.
    assign o_in_ready = i_q_not_full && i_rst_n;
    assign o_q_push   = i_in_valid && o_in_ready;

    // Decode kind and register index into one operation code.
    always_comb begin
        o_q_cmd.wdata  = i_in_item.wdata;
        o_q_cmd.failed = i_in_item.failed;
        o_q_cmd.op     = OP_NOP;
        unique case (i_in_item.kind)
            KIND_REG_WR: begin
                unique case (i_in_item.reg_index)
                    REG_SRC:   o_q_cmd.op = OP_WR_SRC;
                    REG_DST:   o_q_cmd.op = OP_WR_DST;
                    REG_LEN:   o_q_cmd.op = OP_WR_LEN;
                    REG_ABORT: o_q_cmd.op = OP_WR_ABORT;
                    REG_IRQ:   o_q_cmd.op = OP_WR_IRQ;
                    default:   o_q_cmd.op = OP_REG_BAD;
                endcase
            end
            KIND_REG_RD: begin
                unique case (i_in_item.reg_index)
                    REG_SRC: o_q_cmd.op = OP_RD_SRC;
                    REG_DST: o_q_cmd.op = OP_RD_DST;
                    REG_LEN: o_q_cmd.op = OP_RD_LEN;
                    default: o_q_cmd.op = OP_REG_BAD;
                endcase
            end
            KIND_RD_DONE: o_q_cmd.op = OP_RD_DONE;
            KIND_WR_DONE: o_q_cmd.op = OP_WR_DONE;
            KIND_TICK:    o_q_cmd.op = OP_TICK;
            default:      o_q_cmd.op = OP_NOP;
        endcase
    end

endmodule

[hdl/dmac_queue.sv]
// Short command queue between the front and back parts.
// Depends on dmac_pkg for the command type.
module dmac_queue
    import dmac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_not_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    // Pointer advance with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/dmac_back.sv]
// Back part: executes queued commands against the DMA registers and burst
// sequencing state, and holds the result word in an output register. Depends on dmac_pkg.
module dmac_back
    import dmac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int BL  = BURST_LOG2;
    localparam int AW  = ADDR_W;
    localparam logic [LEN_W-1:0] FULL_BURST = LEN_W'(BURST_BYTES);

    // Architectural registers.
    logic [AW-1:0]    r_source,  n_source;
    logic [AW-1:0]    r_dest,    n_dest;
    logic [AW-1:0]    r_length,  n_length;
    logic [AW-1:0]    r_copied,  n_copied;
    logic [LEN_W-1:0] r_chunk,   n_chunk;
    logic             r_split,   n_split;
    logic             r_handling, n_handling;
    logic             r_abort,   n_abort;
    logic             r_pend,    n_pend;
    logic             r_irq_en,  n_irq_en;

    // Running sums: source + copied, dest + copied, and length - copied (signed).
    logic [AW-1:0]    r_src_cur, n_src_cur;
    logic [AW-1:0]    r_dst_cur, n_dst_cur;
    logic [AW:0]      r_rem,     n_rem;

    // Output register.
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        res;

    // Working values.
    logic [AW-1:0]    src_adv, dst_adv, copied_adv;
    logic [AW:0]      rem_adv;
    logic             is_tick;
    logic [AW-1:0]    sr_addr;
    logic [AW:0]      sr_rem;
    logic             sr_done;
    logic [BL-1:0]    sr_mis;
    logic [LEN_W-1:0] sr_burst;
    logic             sr_split;
    logic [LEN_W-1:0] rd_sum;
    logic             rd_cross;
    logic [LEN_W-1:0] rd_burst;
    logic [BL-1:0]    wd_second;
    logic [LEN_W:0]   wd_off;
    logic [AW-1:0]    wd_addr;
    logic             do_read;
    logic             do_finish;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Burst arithmetic shared by the command cases.
    always_comb begin
        src_adv    = r_src_cur + AW'(r_chunk);
        dst_adv    = r_dst_cur + AW'(r_chunk);
        copied_adv = r_copied + AW'(r_chunk);
        rem_adv    = r_rem - (AW + 1)'(r_chunk);
        is_tick    = (i_q_cmd.op == OP_TICK);

        // Next read burst: from the start of a copy or after a finished write.
        sr_addr = is_tick ? r_source : src_adv;
        sr_rem  = is_tick ? {1'b0, r_length} : rem_adv;
        sr_done = sr_rem[AW] || (sr_rem == '0);
        sr_mis  = sr_addr[BL-1:0];
        if (sr_mis != '0) begin
            sr_burst = FULL_BURST - {1'b0, sr_mis};
            sr_split = 1'b1;
        end else begin
            sr_burst = FULL_BURST;
            sr_split = 1'b0;
        end
        if (sr_rem < (AW + 1)'(sr_burst)) begin
            sr_burst = sr_rem[LEN_W-1:0];
            sr_split = 1'b1;
        end

        // Write after a read: split when it crosses a destination boundary.
        rd_sum   = {1'b0, r_dst_cur[BL-1:0]} + r_chunk;
        rd_cross = (rd_sum > FULL_BURST);
        rd_burst = rd_cross ? (FULL_BURST - {1'b0, r_dst_cur[BL-1:0]}) : r_chunk;

        // Second half of a split write. The offset is signed: it goes negative when
        // the split was left over from a read that did not cross a boundary.
        wd_second = r_dst_cur[BL-1:0] + r_chunk[BL-1:0];
        wd_off    = {1'b0, r_chunk} - {2'b00, wd_second};
        wd_addr   = r_dst_cur + {{(AW - LEN_W - 1){wd_off[LEN_W]}}, wd_off};
    end

    // Command execution and result word.
    always_comb begin
        n_source   = r_source;
        n_dest     = r_dest;
        n_length   = r_length;
        n_copied   = r_copied;
        n_chunk    = r_chunk;
        n_split    = r_split;
        n_handling = r_handling;
        n_abort    = r_abort;
        n_pend     = r_pend;
        n_irq_en   = r_irq_en;
        n_src_cur  = r_src_cur;
        n_dst_cur  = r_dst_cur;
        n_rem      = r_rem;
        res        = '0;
        do_read    = 1'b0;
        do_finish  = 1'b0;

        if (o_pop) begin
            unique case (i_q_cmd.op)
                OP_WR_SRC: begin
                    res.access_ok = 1'b1;
                    n_source      = i_q_cmd.wdata;
                    n_src_cur     = i_q_cmd.wdata + r_copied;
                end
                OP_WR_DST: begin
                    res.access_ok = 1'b1;
                    n_dest        = i_q_cmd.wdata;
                    n_dst_cur     = i_q_cmd.wdata + r_copied;
                end
                OP_WR_LEN: begin
                    res.access_ok = 1'b1;
                    n_length      = i_q_cmd.wdata;
                    n_rem         = {1'b0, i_q_cmd.wdata} - {1'b0, r_copied};
                end
                OP_WR_ABORT: begin
                    res.access_ok = 1'b1;
                    n_abort       = 1'b1;
                    n_irq_en      = 1'b0;
                    n_pend        = 1'b0;
                end
                OP_WR_IRQ: begin
                    res.access_ok = 1'b1;
                    n_irq_en      = (i_q_cmd.wdata == '0);
                end
                OP_RD_SRC: begin
                    res.access_ok = 1'b1;
                    res.rdata     = r_source;
                end
                OP_RD_DST: begin
                    res.access_ok = 1'b1;
                    res.rdata     = r_dest;
                end
                OP_RD_LEN: begin
                    res.access_ok = 1'b1;
                    res.rdata     = r_length;
                end
                OP_RD_DONE: begin
                    if (r_handling) begin
                        if (i_q_cmd.failed || r_abort) begin
                            do_finish = 1'b1;
                        end else begin
                            n_split       = rd_cross;
                            res.req_valid = 1'b1;
                            res.req_write = 1'b1;
                            res.req_addr  = r_dst_cur;
                            res.req_len   = rd_burst;
                        end
                    end
                end
                OP_WR_DONE: begin
                    if (r_handling) begin
                        // A whole chunk has landed once no second half is due.
                        if (!r_split) begin
                            n_copied  = copied_adv;
                            n_src_cur = src_adv;
                            n_dst_cur = dst_adv;
                            n_rem     = rem_adv;
                        end
                        if (i_q_cmd.failed || r_abort) begin
                            do_finish = 1'b1;
                        end else if (r_split) begin
                            n_split            = 1'b0;
                            res.req_valid      = 1'b1;
                            res.req_write      = 1'b1;
                            res.req_addr       = wd_addr;
                            res.req_len        = {1'b0, wd_second};
                            res.req_buf_offset = wd_off[BL-1:0];
                        end else begin
                            do_read = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if ((r_length != '0) && !r_handling) begin
                        n_handling = 1'b1;
                        n_copied   = '0;
                        n_src_cur  = r_source;
                        n_dst_cur  = r_dest;
                        n_rem      = {1'b0, r_length};
                        do_read    = 1'b1;
                    end
                end
                default: begin
                    res.access_ok = 1'b0;
                end
            endcase

            // Issue the next read burst, or end the copy when all bytes are done.
            if (do_read) begin
                if (sr_done) begin
                    do_finish = 1'b1;
                end else begin
                    n_split       = sr_split;
                    n_chunk       = sr_burst;
                    res.req_valid = 1'b1;
                    res.req_addr  = sr_addr;
                    res.req_len   = sr_burst;
                end
            end

            // End of copy: clear the length and raise the interrupt if enabled.
            if (do_finish) begin
                if (r_irq_en) begin
                    n_pend = 1'b1;
                end
                n_length   = '0;
                n_abort    = 1'b0;
                n_handling = 1'b0;
            end

            // A tick with no copy running drops a stale abort.
            if (is_tick && !n_handling) begin
                n_abort = 1'b0;
            end
        end

        res.busy_res = n_handling;
        res.irq      = n_pend && n_irq_en;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest      <= '0;
            r_length    <= '0;
            r_copied    <= '0;
            r_chunk     <= '0;
            r_split     <= 1'b0;
            r_handling  <= 1'b0;
            r_abort     <= 1'b0;
            r_pend      <= 1'b0;
            r_irq_en    <= 1'b0;
            r_dst_cur   <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dest     <= n_dest;
            r_length   <= n_length;
            r_copied   <= n_copied;
            r_chunk    <= n_chunk;
            r_split    <= n_split;
            r_handling <= n_handling;
            r_abort    <= n_abort;
            r_pend     <= n_pend;
            r_irq_en   <= n_irq_en;
            r_dst_cur  <= n_dst_cur;
            r_rem      <= n_rem;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Source address and its running sum are undefined until written; result payload.
    always_ff @(posedge i_clk) begin
        r_source  <= n_source;
        r_src_cur <= n_src_cur;
        if (o_pop) begin
            r_out_item <= res;
        end
    end

endmodule

[hdl/dma_burst_copy_controller.sv]
// DMA burst copy controller: register access and burst sequencing for a memory copy.
// An accepted input word is held in the command queue, and its result word is then
// registered in the output register.
// Throughput: one word per cycle; input ready drops only in reset or when the command
// queue is full behind a stalled result word.
// Reset (synchronous, active low) empties the queue and output register and clears all
// control state; the source address register is undefined until written.
module dma_burst_copy_controller
    import dmac_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic q_not_full;
    logic q_not_empty;
    logic q_push;
    logic q_pop;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    // Front part: accept and classify.
    dmac_front u_front (
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_q_not_full (q_not_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    // Command queue.
    dmac_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_cmd       (q_in_cmd),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_out_cmd)
    );

    // Back part: execute and present results.
    dmac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_not_empty),
        .i_q_cmd     (q_out_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // A word without a request carries zero request fields.
    a_idle_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.req_valid) |->
            (o_out_item.req_addr == '0 && o_out_item.req_len == '0 &&
             o_out_item.req_buf_offset == '0 && !o_out_item.req_write))
        else $error("request fields set without a request");

    // No burst request moves more than a full burst of bytes.
    a_req_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.req_valid) |->
            (o_out_item.req_len <= LEN_W'(BURST_BYTES)))
        else $error("burst request length out of range");

    // Read bursts always start at the head of the buffer.
    a_read_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.req_valid && !o_out_item.req_write) |->
            (o_out_item.req_buf_offset == '0))
        else $error("read burst with nonzero buffer offset");

    // A request is only issued while a copy is in progress.
    a_req_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.req_valid) |-> o_out_item.busy_res)
        else $error("burst request issued outside a copy");

endmodule

[sim/tb_dma_burst_copy_controller.sv]
// Self-checking testbench for the DMA burst copy controller.
// Uses dmac_pkg and the dma_burst_copy_controller RTL; a built-in predictor supplies the
// expected result word for every input word that the block accepts.
`timescale 1ns / 1ps

module tb_dma_burst_copy_controller;
    import dmac_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [2:0] REG_UNUSED_LO  = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI  = 3'd7;

    localparam int RANDOM_WORDS  = 1200;
    localparam int DRAIN_EVERY   = 300;
    localparam int FOLLOW_MAX    = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        t_in_item  word;
        t_out_item res;
        bit        hold;
    } t_stim_entry;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    dma_burst_copy_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the controller state.
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [31:0] len_reg;
    logic [31:0] done_bytes;
    logic [6:0]  cur_chunk;
    logic        split_pend;
    logic        copying;
    logic        abort_req;
    logic        irq_pend;
    logic        irq_en;
    t_out_item   step_res;

    // Stimulus and checking bookkeeping.
    t_stim_entry stim_words[$];
    t_out_item   expected_results[$];
    t_out_item   cur_res;
    bit          in_taken     = 1'b0;
    bit          last_req_write = 1'b0;
    int          stim_count   = 0;
    int          next_drain   = 40;
    int          fail_count   = 0;
    int          cycle_count  = 0;
    int          in_gap       = 0;
    int          in_calm      = 0;
    int          out_stall    = 0;
    int          out_calm     = 0;

    task automatic reset_shadow();
        src_reg    = '0;
        dst_reg    = '0;
        len_reg    = '0;
        done_bytes = '0;
        cur_chunk  = '0;
        split_pend = 1'b0;
        copying    = 1'b0;
        abort_req  = 1'b0;
        irq_pend   = 1'b0;
        irq_en     = 1'b0;
    endtask

    task automatic issue_req(input logic wr, input logic [31:0] addr, input logic [31:0] len,
                             input logic [31:0] off);
        step_res.req_valid      = 1'b1;
        step_res.req_write      = wr;
        step_res.req_addr       = addr;
        step_res.req_len        = len[LEN_W-1:0];
        step_res.req_buf_offset = off[BURST_LOG2-1:0];
    endtask

    task automatic end_copy();
        if (irq_en) irq_pend = 1'b1;
        len_reg   = '0;
        abort_req = 1'b0;
        copying   = 1'b0;
    endtask

    // Next read burst: cut at the source burst boundary and at the remaining length.
    task automatic next_read();
        logic [31:0] remain;
        logic [31:0] addr;
        logic [31:0] burst;
        if (done_bytes >= len_reg) begin
            end_copy();
            return;
        end
        remain     = len_reg - done_bytes;
        addr       = src_reg + done_bytes;
        burst      = BURST_BYTES;
        split_pend = 1'b0;
        if (addr[BURST_LOG2-1:0] != '0) begin
            burst      = BURST_BYTES - addr[BURST_LOG2-1:0];
            split_pend = 1'b1;
        end
        if (remain < burst) begin
            burst      = remain;
            split_pend = 1'b1;
        end
        cur_chunk = burst[6:0];
        issue_req(1'b0, addr, burst, 32'd0);
    endtask

    // A finished read is written back, split when it crosses a destination boundary.
    task automatic rd_burst_done(input logic bad);
        logic [31:0] head_addr;
        logic [31:0] tail_addr;
        logic [31:0] burst;
        if (bad || abort_req) begin
            end_copy();
            return;
        end
        head_addr  = dst_reg + done_bytes;
        tail_addr  = head_addr + 32'(cur_chunk) - 32'd1;
        burst      = 32'(cur_chunk);
        split_pend = 1'b0;
        if (head_addr[31:BURST_LOG2] != tail_addr[31:BURST_LOG2]) begin
            burst      = BURST_BYTES - head_addr[BURST_LOG2-1:0];
            split_pend = 1'b1;
        end
        issue_req(1'b1, head_addr, burst, 32'd0);
    endtask

    task automatic write_done(input logic bad);
        logic [31:0] tail;
        logic [31:0] second;
        logic [31:0] off;
        second = '0;
        off    = '0;
        if (split_pend) begin
            tail   = dst_reg + done_bytes + 32'(cur_chunk);
            second = tail & 32'(BURST_BYTES - 1);
            off    = 32'(cur_chunk) - second;
        end else begin
            done_bytes = done_bytes + 32'(cur_chunk);
        end
        if (bad || abort_req) begin
            end_copy();
            return;
        end
        if (split_pend) begin
            split_pend = 1'b0;
            issue_req(1'b1, dst_reg + done_bytes + off, second, off);
            return;
        end
        next_read();
    endtask

    // Expected result word for one input word; advances the shadow state.
    task automatic dma_step(input t_in_item w, output t_out_item r);
        step_res = '0;
        case (w.kind)
            KIND_REG_WR: begin
                step_res.access_ok = 1'b1;
                case (w.reg_index)
                    REG_SRC: src_reg = w.wdata;
                    REG_DST: dst_reg = w.wdata;
                    REG_LEN: len_reg = w.wdata;
                    REG_ABORT: begin
                        abort_req = 1'b1;
                        irq_en    = 1'b0;
                        irq_pend  = 1'b0;
                    end
                    REG_IRQ: irq_en = (w.wdata == '0);
                    default: step_res.access_ok = 1'b0;
                endcase
            end
            KIND_REG_RD: begin
                step_res.access_ok = 1'b1;
                case (w.reg_index)
                    REG_SRC: step_res.rdata = src_reg;
                    REG_DST: step_res.rdata = dst_reg;
                    REG_LEN: step_res.rdata = len_reg;
                    default: step_res.access_ok = 1'b0;
                endcase
            end
            KIND_RD_DONE: if (copying) rd_burst_done(w.failed);
            KIND_WR_DONE: if (copying) write_done(w.failed);
            KIND_TICK: begin
                if (len_reg != '0 && !copying) begin
                    copying    = 1'b1;
                    done_bytes = '0;
                    next_read();
                end
                if (!copying) abort_req = 1'b0;
            end
            default: ;
        endcase
        step_res.busy_res = copying;
        step_res.irq      = irq_pend && irq_en;
        r = step_res;
    endtask

    // Queue one word together with its predicted result.
    task automatic push_word(input logic [2:0] kind, input logic [2:0] idx,
                             input logic [31:0] data, input logic bad);
        t_stim_entry e;
        e.word.kind      = kind;
        e.word.reg_index = idx;
        e.word.wdata     = data;
        e.word.failed    = bad;
        dma_step(e.word, e.res);
        e.hold = 1'b0;
        if (stim_count >= next_drain) begin
            e.hold     = 1'b1;
            next_drain = next_drain + DRAIN_EVERY;
        end
        if (e.res.req_valid) last_req_write = e.res.req_write;
        stim_words.push_back(e);
        stim_count++;
    endtask

    // Answer each memory request until the copy ends, with optional interference.
    task automatic follow_copy(input bit with_noise);
        int       steps;
        int       r;
        logic [2:0] done_kind;
        logic [2:0] wrong_kind;
        steps = 0;
        while (copying) begin
            done_kind  = last_req_write ? KIND_WR_DONE : KIND_RD_DONE;
            wrong_kind = last_req_write ? KIND_RD_DONE : KIND_WR_DONE;
            r = with_noise ? $urandom_range(0, 99) : 99;
            steps++;
            if (steps == FOLLOW_MAX)
                push_word(KIND_REG_WR, REG_ABORT, $urandom, 1'b0);
            else if (steps > FOLLOW_MAX || r >= 10)
                push_word(done_kind, 3'($urandom_range(0, 7)), $urandom,
                          with_noise && ($urandom_range(0, 39) == 0));
            else if (r < 3)
                push_word(KIND_REG_RD, 3'($urandom_range(0, 7)), $urandom,
                          1'($urandom_range(0, 1)));
            else if (r < 5)
                push_word(KIND_REG_WR, REG_LEN, $urandom_range(0, 300), 1'b0);
            else if (r < 6)
                push_word(KIND_REG_WR, REG_ABORT, $urandom, 1'b0);
            else if (r < 7)
                push_word(KIND_TICK, 3'($urandom_range(0, 7)), $urandom, 1'b0);
            else if (r < 8)
                push_word(KIND_REG_WR, REG_IRQ, $urandom_range(0, 1), 1'b0);
            else
                push_word(wrong_kind, 3'($urandom_range(0, 7)), $urandom,
                          1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom;
        if (r < 55) return $urandom & ~32'(BURST_BYTES - 1);
        if (r < 75) return 32'hFFFF_FFC0 | 32'($urandom_range(0, BURST_BYTES - 1));
        return ($urandom & ~32'(BURST_BYTES - 1)) |
               32'($urandom_range(BURST_BYTES - 4, BURST_BYTES - 1));
    endfunction

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 32'd0;
        if (r < 13) return $urandom_range(1, 4);
        if (r < 78) return $urandom_range(5, 200);
        if (r < 95) return $urandom_range(201, 1100);
        if (r < 98) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // A complete copy: program the registers, start it and see it through.
    task automatic random_copy();
        if (copying) follow_copy(1'b1);
        push_word(KIND_REG_WR, REG_SRC, pick_addr(), 1'b0);
        push_word(KIND_REG_WR, REG_DST, pick_addr(), 1'b0);
        push_word(KIND_REG_WR, REG_LEN, pick_len(), 1'b0);
        if ($urandom_range(0, 1))
            push_word(KIND_REG_WR, REG_IRQ, $urandom_range(0, 1) ? 32'd0 : $urandom, 1'b0);
        if ($urandom_range(0, 11) == 0)
            push_word(KIND_REG_WR, REG_ABORT, $urandom, 1'b0);
        if ($urandom_range(0, 9) == 0)
            push_word(KIND_REG_RD, 3'($urandom_range(0, 2)), $urandom, 1'b0);
        push_word(KIND_TICK, 3'($urandom_range(0, 7)), $urandom, 1'b0);
        follow_copy(1'b1);
    endtask

    // Idle length: mostly short, a few long, with occasional calm stretches.
    task automatic pick_gap(inout int calm, output int gap);
        int r;
        if (calm > 0) begin
            calm--;
            gap = 0;
            return;
        end
        if ($urandom_range(0, 49) == 0) calm = 40;
        r = $urandom_range(0, 99);
        if (r < 55)      gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 8);
        else             gap = $urandom_range(15, 40);
    endtask

    // Driver: presents queued words at the falling edge and holds each until accepted.
    always @(negedge i_clk) begin : word_driver
        logic        nv;
        t_in_item    ni;
        t_stim_entry e;
        nv = in_valid;
        ni = in_item;
        if (in_taken) begin
            in_taken = 1'b0;
            nv = 1'b0;
        end
        if (i_rst_n && !nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (stim_words.size() != 0 &&
                         !(stim_words[0].hold && expected_results.size() != 0)) begin
                e       = stim_words.pop_front();
                ni      = e.word;
                cur_res = e.res;
                nv      = 1'b1;
                pick_gap(in_calm, in_gap);
            end
        end
        in_valid <= nv;
        in_item  <= ni;
    end

    // Result-side back-pressure.
    always @(negedge i_clk) begin : ready_driver
        logic nr;
        nr = 1'b1;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            nr = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            pick_gap(out_calm, out_stall);
        end
        out_ready <= nr;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: records accepted words and checks each result word in order.
    always @(posedge i_clk) begin : word_monitor
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(cur_res);
                in_taken = 1'b1;
            end
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("rdata", want.rdata, o_out_item.rdata);
                    check_field("access_ok", 32'(want.access_ok), 32'(o_out_item.access_ok));
                    check_field("req_valid", 32'(want.req_valid), 32'(o_out_item.req_valid));
                    check_field("req_write", 32'(want.req_write), 32'(o_out_item.req_write));
                    check_field("req_addr", want.req_addr, o_out_item.req_addr);
                    check_field("req_len", 32'(want.req_len), 32'(o_out_item.req_len));
                    check_field("req_buf_offset", 32'(want.req_buf_offset),
                                32'(o_out_item.req_buf_offset));
                    check_field("busy_res", 32'(want.busy_res), 32'(o_out_item.busy_res));
                    check_field("irq", 32'(want.irq), 32'(o_out_item.irq));
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int base;
        int r;
        int n;
        reset_shadow();

        // Directed words: register extremes, undecoded accesses, unknown kinds,
        // stray completions, idle abort, and short copies.
        push_word(KIND_REG_WR, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_RD, REG_SRC, 32'hFFFF_FFFF, 1'b1);
        push_word(KIND_REG_WR, REG_SRC, 32'hFFFF_FFFF, 1'b1);
        push_word(KIND_REG_RD, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_DST, 32'hFFFF_FFFF, 1'b0);
        push_word(KIND_REG_RD, REG_DST, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_LEN, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_RD, REG_LEN, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_UNUSED_LO, 32'hFFFF_FFFF, 1'b0);
        push_word(KIND_REG_WR, REG_UNUSED_HI, 32'h1234_5678, 1'b0);
        push_word(KIND_REG_RD, REG_ABORT, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_RD, REG_UNUSED_HI, 32'h0000_0000, 1'b0);
        push_word(KIND_UNUSED_LO, REG_SRC, 32'hFFFF_FFFF, 1'b1);
        push_word(KIND_UNUSED_HI, REG_LEN, 32'h0000_0001, 1'b0);
        push_word(KIND_RD_DONE, REG_SRC, 32'h0000_0000, 1'b1);
        push_word(KIND_WR_DONE, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_ABORT, 32'h0000_0000, 1'b0);
        push_word(KIND_TICK, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_IRQ, 32'hFFFF_FFFF, 1'b0);
        push_word(KIND_REG_WR, REG_IRQ, 32'h0000_0000, 1'b0);
        // Misaligned source near the top of memory; destination writes do not cross a burst boundary.
        push_word(KIND_REG_WR, REG_SRC, 32'hFFFF_FFF0, 1'b0);
        push_word(KIND_REG_WR, REG_DST, 32'h0000_0030, 1'b0);
        push_word(KIND_REG_WR, REG_LEN, 32'd100, 1'b0);
        push_word(KIND_TICK, REG_SRC, 32'h0000_0000, 1'b0);
        follow_copy(1'b0);
        // A failed read ends the copy at once.
        push_word(KIND_REG_WR, REG_LEN, 32'd8, 1'b0);
        push_word(KIND_TICK, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_RD_DONE, REG_SRC, 32'h0000_0000, 1'b1);
        // An abort left pending at start ends the copy at its first completion.
        push_word(KIND_REG_WR, REG_ABORT, 32'h0000_0000, 1'b0);
        push_word(KIND_REG_WR, REG_LEN, 32'd20, 1'b0);
        push_word(KIND_TICK, REG_SRC, 32'h0000_0000, 1'b0);
        push_word(KIND_RD_DONE, REG_SRC, 32'h0000_0000, 1'b0);

        // Random part: mostly complete copies, the rest noise words.
        base = stim_count;
        while (stim_count < base + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                random_copy();
            end else begin
                n = $urandom_range(1, 6);
                repeat (n)
                    push_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
                              1'($urandom_range(0, 1)));
            end
        end
        if (copying) follow_copy(1'b1);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected result words never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/dmac_pkg.sv
hdl/dmac_front.sv
hdl/dmac_queue.sv
hdl/dmac_back.sv
hdl/dma_burst_copy_controller.sv
sim/tb_dma_burst_copy_controller.sv
